/* rtl/rpn_pkg.sv */
// Shared constants for the RPN stack evaluator.
package rpn_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = 7;
   localparam int WIDE_W      = (LEVEL_W > COUNT_W) ? LEVEL_W : COUNT_W;
   localparam int DATA_W      = 32;

   localparam logic [3:0] ACT_NUMBER = 4'd0;
   localparam logic [3:0] ACT_ADD    = 4'd1;
   localparam logic [3:0] ACT_SUB    = 4'd2;
   localparam logic [3:0] ACT_MUL    = 4'd3;
   localparam logic [3:0] ACT_DIV    = 4'd4;
   localparam logic [3:0] ACT_SELECT = 4'd5;
   localparam logic [3:0] ACT_NEGATE = 4'd6;
   localparam logic [3:0] ACT_MAX    = 4'd7;
   localparam logic [3:0] ACT_MIN    = 4'd8;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_UNDER   = 2'd2;
   localparam logic [1:0] ST_OVER    = 2'd3;

endpackage

/* rtl/rpn_if.sv */
// Token and result channel interfaces.
interface rpn_req_if;
   logic                           valid;
   logic                           ready;
   logic [3:0]                     action;
   logic signed [rpn_pkg::DATA_W-1:0] operand;
   logic [rpn_pkg::COUNT_W-1:0]    reduce_count;
   logic                           last;
   modport source (output valid, action, operand, reduce_count, last, input ready);
   modport sink   (input valid, action, operand, reduce_count, last, output ready);
endinterface

interface rpn_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [rpn_pkg::DATA_W-1:0] result;
   logic [1:0]                     status;
   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface

/* rtl/rpn_stack_evaluator.sv */
// Top level of the RPN stack evaluator: sequencer, stack memory and shared ALU.
// Sequence: a number token is pushed in the idle state; an operator needing n operands
// reads them one at a time, each a registered stack read (S_RD, S_CAP), then executes;
// divide then runs the one-bit-per-cycle divider; a last token adds the empty check,
// the top read, its capture and the output register load, which waits on a stalled output.
// Flow: one token at a time, ready only when idle. Reset: synchronous, empties
// the stack, clears discard mode and the output valid flag.
module rpn_stack_evaluator (
   input  logic      clock,
   input  logic      reset,
   rpn_req_if.sink   req_ch,
   rpn_rsp_if.source rsp_ch
);
   localparam int DW = rpn_pkg::DATA_W;
   localparam int LW = rpn_pkg::LEVEL_W;
   localparam int AW = rpn_pkg::ADDR_W;
   localparam int CW = rpn_pkg::COUNT_W;
   localparam int WW = rpn_pkg::WIDE_W;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_RD   = 9'b000000010,
      S_CAP  = 9'b000000100,
      S_EXEC = 9'b000001000,
      S_DIV  = 9'b000010000,
      S_POST = 9'b000100000,
      S_FRD  = 9'b001000000,
      S_FCAP = 9'b010000000,
      S_EMIT = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic [LW-1:0] level_ff, level_in;
   logic          disc_ff, disc_in;
   logic [3:0]    act_ff, act_in;
   logic          last_ff, last_in;
   logic [CW-1:0] need_ff, need_in;
   logic [CW-1:0] k_ff, k_in;
   logic [DW-1:0] op1_ff, op1_in;
   logic [DW-1:0] op2_ff, op2_in;
   logic [DW-1:0] op3_ff, op3_in;
   logic [DW-1:0] emit_val_ff, emit_val_in;
   logic [1:0]    emit_st_ff, emit_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_result_ff, rsp_result_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   // stack memory, registered read
   logic [DW-1:0] stack_mem [rpn_pkg::STACK_DEPTH];
   logic [DW-1:0] mem_q;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic          we;

   logic [CW-1:0] need_w;
   logic [WW-1:0] level_wide;
   logic [DW-1:0] alu_w;
   logic          cmp_gt;
   logic          div_start;
   logic          div_done;
   logic [DW-1:0] div_q;
   logic [DW-1:0] prod_w;

   assign level_wide = WW'(level_ff);

   // operand count of the token on the input channel
   always_comb begin
      case (req_ch.action)
         rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB,
         rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: need_w = CW'(2);
         rpn_pkg::ACT_SELECT:               need_w = CW'(3);
         rpn_pkg::ACT_NEGATE:               need_w = CW'(1);
         rpn_pkg::ACT_MAX, rpn_pkg::ACT_MIN:
            need_w = (req_ch.reduce_count == '0) ? CW'(1) : req_ch.reduce_count;
         default:                           need_w = '0;
      endcase
   end

   // shared signed compare: new value beats the running best
   assign cmp_gt = (act_ff == rpn_pkg::ACT_MAX) ? ($signed(mem_q) > $signed(op1_ff))
                                               : ($signed(op1_ff) > $signed(mem_q));

   // only the low word of the product is kept
   assign prod_w = op1_ff * op2_ff;

   always_comb begin
      case (act_ff)
         rpn_pkg::ACT_ADD:    alu_w = op1_ff + op2_ff;
         rpn_pkg::ACT_SUB:    alu_w = op2_ff - op1_ff;
         rpn_pkg::ACT_MUL:    alu_w = prod_w;
         rpn_pkg::ACT_DIV:    alu_w = div_q;
         rpn_pkg::ACT_SELECT: alu_w = ($signed(op3_ff) > 0) ? op2_ff : op1_ff;
         rpn_pkg::ACT_NEGATE: alu_w = DW'(0) - op1_ff;
         default:             alu_w = op1_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      disc_in       = disc_ff;
      act_in        = act_ff;
      last_in       = last_ff;
      need_in       = need_ff;
      k_in          = k_ff;
      op1_in        = op1_ff;
      op2_in        = op2_ff;
      op3_in        = op3_ff;
      emit_val_in   = emit_val_ff;
      emit_st_in    = emit_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = AW'(level_wide - WW'(k_ff));
      wr_addr       = AW'(level_wide - WW'(need_ff));
      wr_data       = alu_w;
      we            = 1'b0;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in  = req_ch.action;
               last_in = req_ch.last;
               need_in = need_w;
               k_in    = CW'(1);
               if (disc_ff) begin
                  // drop tokens of a failed expression up to its last
                  if (req_ch.last) begin
                     disc_in  = 1'b0;
                     level_in = '0;
                  end
               end else if (req_ch.action == rpn_pkg::ACT_NUMBER) begin
                  if (level_wide >= WW'(rpn_pkg::STACK_DEPTH)) begin
                     level_in    = '0;
                     disc_in     = !req_ch.last;
                     emit_val_in = '0;
                     emit_st_in  = rpn_pkg::ST_OVER;
                     state_in    = S_EMIT;
                  end else begin
                     we       = 1'b1;
                     wr_addr  = AW'(level_wide);
                     wr_data  = req_ch.operand;
                     level_in = level_ff + LW'(1);
                     state_in = req_ch.last ? S_POST : S_IDLE;
                  end
               end else if (WW'(need_w) > level_wide) begin
                  level_in    = '0;
                  disc_in     = !req_ch.last;
                  emit_val_in = '0;
                  emit_st_in  = rpn_pkg::ST_UNDER;
                  state_in    = S_EMIT;
               end else if (need_w == '0) begin
                  state_in = req_ch.last ? S_POST : S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            // address issued, data lands next cycle
            state_in = S_CAP;
         end
         S_CAP: begin
            if (k_ff == CW'(1)) begin
               op1_in = mem_q;
            end else if (act_ff == rpn_pkg::ACT_MAX || act_ff == rpn_pkg::ACT_MIN) begin
               if (cmp_gt) begin
                  op1_in = mem_q;
               end
            end else if (k_ff == CW'(2)) begin
               op2_in = mem_q;
            end else begin
               op3_in = mem_q;
            end
            if (k_ff == need_ff) begin
               state_in = S_EXEC;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_EXEC: begin
            if (act_ff == rpn_pkg::ACT_DIV) begin
               if (op1_ff == '0) begin
                  level_in    = '0;
                  disc_in     = !last_ff;
                  emit_val_in = '0;
                  emit_st_in  = rpn_pkg::ST_DIVZERO;
                  state_in    = S_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               we       = 1'b1;
               level_in = LW'(level_wide - WW'(need_ff) + WW'(1));
               state_in = last_ff ? S_POST : S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               we       = 1'b1;
               level_in = LW'(level_wide - WW'(need_ff) + WW'(1));
               state_in = last_ff ? S_POST : S_IDLE;
            end
         end
         S_POST: begin
            if (level_ff == '0) begin
               disc_in     = 1'b0;
               emit_val_in = '0;
               emit_st_in  = rpn_pkg::ST_UNDER;
               state_in    = S_EMIT;
            end else begin
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            rd_addr  = AW'(level_wide - WW'(1));
            state_in = S_FCAP;
         end
         S_FCAP: begin
            emit_val_in = mem_q;
            emit_st_in  = rpn_pkg::ST_OK;
            level_in    = '0;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = emit_val_ff;
               rsp_status_in = emit_st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         stack_mem[wr_addr] <= wr_data;
      end
      mem_q <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      last_ff       <= last_in;
      need_ff       <= need_in;
      k_ff          <= k_in;
      op1_ff        <= op1_in;
      op2_ff        <= op2_in;
      op3_ff        <= op3_in;
      emit_val_ff   <= emit_val_in;
      emit_st_ff    <= emit_st_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (op2_ff),
      .divisor  (op1_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = rsp_result_ff;
   assign rsp_ch.status = rsp_status_ff;
endmodule

/* rtl/rpn_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpn_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rpn_pkg::DATA_W-1:0]       dividend,
   input  logic [rpn_pkg::DATA_W-1:0]       divisor,
   output logic                             done,
   output logic [rpn_pkg::DATA_W-1:0]       quotient
);
   localparam int W     = rpn_pkg::DATA_W;
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     q_ff, q_in;
   logic [W:0]       rem_ff, rem_in;
   logic [W-1:0]     den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       rem_sh;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[W-1:0], q_ff[W-1]};
      if (start) begin
         q_in   = dividend[W-1] ? (W'(0) - dividend) : dividend;
         den_in = divisor[W-1] ? (W'(0) - divisor) : divisor;
         neg_in = dividend[W-1] ^ divisor[W-1];
         rem_in = '0;
         cnt_in = CNT_W'(W);
      end else if (cnt_ff != '0) begin
         // shift in one dividend bit, subtract where it fits
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - q_ff) : q_ff;
endmodule

/* rtl/rpn_checker.sv */
// Port-level assertions for the RPN stack evaluator, bound to the top level.
module rpn_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rpn_pkg::DATA_W-1:0] rsp_result,
   input logic [1:0]                 rsp_status,
   input logic                       req_valid,
   input logic                       req_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rpn_pkg::ST_OK |-> rsp_result == '0)
      else $error("error word carries nonzero result");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset left output valid or input blocked");

   // a new result word is loaded only while the input side is blocked
   a_rsp_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result word raised right after a token accept");
endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_result (rsp_ch.result),
   .rsp_status (rsp_ch.status),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready)
);

/* sim/tb_top.sv */
// Testbench for the RPN stack evaluator: directed table, then random expressions.
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic [3:0]         action;
      logic signed [31:0] operand;
      logic [6:0]         reduce_count;
      logic               last;
   } token_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [1:0]         status;
   } outcome_type;

   // One directed row: the token, whether a result is typed in, and that result.
   typedef struct packed {
      token_type   tok;
      logic        fixed;
      outcome_type want;
   } row_type;

   localparam int LIMIT = 2_000_000;

   logic clock;
   logic reset;
   rpn_req_if req_ch ();
   rpn_rsp_if rsp_ch ();

   rpn_stack_evaluator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Predictor state: its own stack, level and discard flag.
   logic signed [31:0] eval_stack [rpn_pkg::STACK_DEPTH];
   int unsigned        eval_level;
   bit                 eval_skip;

   outcome_type expected_q[$];
   int       mismatches;
   int       cycles;
   bit       calm;          // no idling in the last part of the run
   bit       sink_busy;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic bit sgt(input logic signed [31:0] x, input logic signed [31:0] y);
      return x > y;
   endfunction

   // Fail the current expression: empty the stack, skip the rest unless last.
   function automatic outcome_type eval_fail(input logic [1:0] st, input bit is_last);
      outcome_type o;
      eval_level = 0;
      eval_skip  = !is_last;
      o.result = '0;
      o.status = st;
      return o;
   endfunction

   // Evaluate one token; return 1 when a word is due, with its value in o.
   function automatic bit eval_token(input token_type t, output outcome_type o);
      int unsigned need;
      logic signed [31:0] a, b, c, best, v;
      logic [31:0] am, bm, q;
      o = '0;
      if (eval_skip) begin
         if (t.last) begin
            eval_skip  = 0;
            eval_level = 0;
         end
         return 0;
      end
      case (t.action)
         rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: need = 2;
         rpn_pkg::ACT_SELECT: need = 3;
         rpn_pkg::ACT_NEGATE: need = 1;
         rpn_pkg::ACT_MAX, rpn_pkg::ACT_MIN:
            need = (t.reduce_count == 0) ? 1 : t.reduce_count;
         default: need = 0;
      endcase
      if (t.action == rpn_pkg::ACT_NUMBER) begin
         if (eval_level >= rpn_pkg::STACK_DEPTH) begin
            o = eval_fail(rpn_pkg::ST_OVER, t.last);
            return 1;
         end
         eval_stack[eval_level] = t.operand;
         eval_level++;
      end else if (need > eval_level) begin
         o = eval_fail(rpn_pkg::ST_UNDER, t.last);
         return 1;
      end else if (t.action >= rpn_pkg::ACT_ADD && t.action <= rpn_pkg::ACT_DIV) begin
         a = eval_stack[eval_level-1];
         b = eval_stack[eval_level-2];
         if (t.action == rpn_pkg::ACT_DIV && a == 0) begin
            o = eval_fail(rpn_pkg::ST_DIVZERO, t.last);
            return 1;
         end
         case (t.action)
            rpn_pkg::ACT_ADD: c = a + b;
            rpn_pkg::ACT_SUB: c = b - a;
            rpn_pkg::ACT_MUL: c = a * b;
            default: begin
               // Truncate toward zero on magnitudes; min / -1 wraps naturally.
               am = a[31] ? -a : a;
               bm = b[31] ? -b : b;
               q  = bm / am;
               c  = (a[31] != b[31]) ? -q : q;
            end
         endcase
         eval_level--;
         eval_stack[eval_level-1] = c;
      end else if (t.action == rpn_pkg::ACT_SELECT) begin
         c = eval_stack[eval_level-1];
         b = eval_stack[eval_level-2];
         a = eval_stack[eval_level-3];
         eval_level -= 2;
         eval_stack[eval_level-1] = sgt(a, 0) ? b : c;
      end else if (t.action == rpn_pkg::ACT_NEGATE) begin
         eval_stack[eval_level-1] = -eval_stack[eval_level-1];
      end else if (t.action == rpn_pkg::ACT_MAX || t.action == rpn_pkg::ACT_MIN) begin
         best = eval_stack[eval_level-1];
         for (int i = 2; i <= need; i++) begin
            v = eval_stack[eval_level-i];
            if (t.action == rpn_pkg::ACT_MAX ? sgt(v, best) : sgt(best, v)) best = v;
         end
         eval_level -= need - 1;
         eval_stack[eval_level-1] = best;
      end
      if (!t.last) return 0;
      if (eval_level == 0) begin
         o = eval_fail(rpn_pkg::ST_UNDER, 1);
         return 1;
      end
      o.result = eval_stack[eval_level-1];
      o.status = rpn_pkg::ST_OK;
      eval_level = 0;
      return 1;
   endfunction

   function automatic token_type mk(input logic [3:0] act, input logic signed [31:0] opd,
                                    input logic [6:0] cnt, input bit lst);
      token_type t;
      t.action = act; t.operand = opd; t.reduce_count = cnt; t.last = lst;
      return t;
   endfunction

   // Drive one word and hold it until accepted; predict at acceptance.
   // Valid stays high on return; an idle gap drops it first.
   task automatic send_token(input token_type t, input bit fixed, input outcome_type want);
      outcome_type o;
      bit due;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= t.action;
      req_ch.operand      <= t.operand;
      req_ch.reduce_count <= t.reduce_count;
      req_ch.last         <= t.last;
      do @(posedge clock); while (!req_ch.ready);
      due = eval_token(t, o);
      if (fixed && (!due || o != want))
         report($sformatf("directed row action %0d: table and predictor disagree", t.action));
      if (due) expected_q.push_back(o);
      @(negedge clock);
   endtask

   // Random operand: mix of extremes, small values and full range.
   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return $signed($urandom_range(0, 6)) - 3;
         3: return $signed($urandom_range(0, 200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   // Well-formed expression: keep depth in mind, pick valid operators.
   task automatic send_expression(output int count_out);
      int depth, len, op, cnt;
      token_type t;
      len = $urandom_range(1, 12);
      depth = 0;
      for (int k = 0; k < len; k++) begin
         op = $urandom_range(0, 9);
         if (depth == 0 || op >= 9 || (op == 0)) begin
            t = mk(rpn_pkg::ACT_NUMBER, rand_value(), 7'($urandom), 0);
            depth++;
         end else begin
            case (op)
               1, 2, 3: t = mk(4'(rpn_pkg::ACT_ADD + $urandom_range(0, 2)), $urandom,
                               7'($urandom), 0);
               4: t = mk(rpn_pkg::ACT_DIV, $urandom, 7'($urandom), 0);
               5: t = mk(rpn_pkg::ACT_SELECT, $urandom, 7'($urandom), 0);
               6: t = mk(rpn_pkg::ACT_NEGATE, $urandom, 7'($urandom), 0);
               default: begin
                  cnt = $urandom_range(0, depth);
                  t = mk(op == 7 ? rpn_pkg::ACT_MAX : rpn_pkg::ACT_MIN, $urandom,
                         cnt[6:0], 0);
               end
            endcase
            if (t.action >= rpn_pkg::ACT_ADD && t.action <= rpn_pkg::ACT_DIV && depth < 2 ||
                t.action == rpn_pkg::ACT_SELECT && depth < 3) begin
               t = mk(rpn_pkg::ACT_NUMBER, rand_value(), 7'($urandom), 0);
               depth++;
            end else if (t.action == rpn_pkg::ACT_SELECT) depth -= 2;
            else if (t.action <= rpn_pkg::ACT_DIV) depth -= 1;
            else if (t.action == rpn_pkg::ACT_MAX || t.action == rpn_pkg::ACT_MIN)
               depth -= (t.reduce_count == 0) ? 0 : t.reduce_count - 1;
         end
         if (k == len - 1) t.last = 1;
         send_token(t, 0, '0);
      end
      count_out = len;
   endtask

   // Sink side: stall at random, check each accepted word against the queue.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (sink_busy) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= 1'b1;
   end

   initial begin
      int n;
      sink_busy = 0;
      forever begin
         @(negedge clock);
         if (!calm && !sink_busy && $urandom_range(0, 6) == 0) begin
            sink_busy = 1;
            n = $urandom_range(1, 3);
            repeat (n) @(negedge clock);
            sink_busy = 0;
         end
      end
   end

   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            report("result word with nothing expected");
         end else begin
            w = expected_q.pop_front();
            if (rsp_ch.result !== w.result)
               report($sformatf("result %0d, expected %0d", rsp_ch.result, w.result));
            if (rsp_ch.status !== w.status)
               report($sformatf("status %0d, expected %0d", rsp_ch.status, w.status));
         end
      end
   end

   // Watchdog: end the run at a generous cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   row_type dir_rows[$];

   task automatic add_row(input token_type t, input bit fx, input logic signed [31:0] r,
                          input logic [1:0] s);
      row_type x;
      x.tok = t; x.fixed = fx; x.want.result = r; x.want.status = s;
      dir_rows.push_back(x);
   endtask

   initial begin
      int sent;
      int got;
      mismatches = 0; cycles = 0; calm = 0;
      eval_level = 0; eval_skip = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.action = rpn_pkg::ACT_NUMBER; req_ch.operand = '0;
      req_ch.reduce_count = '0; req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: extremes, every operator, underflow and divide by zero.
      add_row(mk(rpn_pkg::ACT_ADD, 0, 0, 1), 1, 0, rpn_pkg::ST_UNDER); // underflow after reset
      add_row(mk(rpn_pkg::ACT_NUMBER, 32'sh7FFF_FFFF, 0, 1), 1, 32'sh7FFF_FFFF, rpn_pkg::ST_OK);
      add_row(mk(rpn_pkg::ACT_NUMBER, 32'sh8000_0000, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NUMBER, -1, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_DIV, 0, 0, 1), 1, 32'sh8000_0000, rpn_pkg::ST_OK); // min / -1
      add_row(mk(rpn_pkg::ACT_NUMBER, 7, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NUMBER, 0, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_DIV, 0, 0, 0), 1, 0, rpn_pkg::ST_DIVZERO);   // divide by zero
      add_row(mk(rpn_pkg::ACT_NUMBER, 5, 0, 0), 0, 0, 0);                  // discarded
      add_row(mk(rpn_pkg::ACT_NUMBER, 5, 0, 1), 0, 0, 0);                  // ends discard
      add_row(mk(rpn_pkg::ACT_NUMBER, -7, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NUMBER, 2, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_SUB, 0, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NUMBER, 3, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_MUL, 0, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NUMBER, 4, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NUMBER, 9, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_SELECT, 0, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_NEGATE, 0, 0, 0), 0, 0, 0);
      add_row(mk(4'd15, 0, 0, 1), 0, 0, 0);                          // unknown action on last
      add_row(mk(4'd9, 0, 0, 1), 1, 0, rpn_pkg::ST_UNDER);           // empty at last
      add_row(mk(rpn_pkg::ACT_NUMBER, 1, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_MAX, 0, 0, 0), 0, 0, 0);               // zero count acts as one
      add_row(mk(rpn_pkg::ACT_NUMBER, 6, 0, 0), 0, 0, 0);
      add_row(mk(rpn_pkg::ACT_MIN, 0, 7'd127, 1), 1, 0, rpn_pkg::ST_UNDER); // count too big
      foreach (dir_rows[i]) send_token(dir_rows[i].tok, dir_rows[i].fixed, dir_rows[i].want);

      // Overflow: fill the stack, then push once more.
      for (int i = 0; i <= rpn_pkg::STACK_DEPTH; i++)
         send_token(mk(rpn_pkg::ACT_NUMBER, i, 0, i == rpn_pkg::STACK_DEPTH),
                    i == rpn_pkg::STACK_DEPTH, {32'sd0, rpn_pkg::ST_OVER});
      // Full-depth max, then min over 64 operands.
      for (int i = 0; i < rpn_pkg::STACK_DEPTH; i++)
         send_token(mk(rpn_pkg::ACT_NUMBER, rand_value(), 0, 0), 0, '0);
      send_token(mk(rpn_pkg::ACT_MAX, 0, 7'(rpn_pkg::STACK_DEPTH), 1), 0, '0);
      for (int i = 0; i < rpn_pkg::STACK_DEPTH; i++)
         send_token(mk(rpn_pkg::ACT_NUMBER, rand_value(), 0, 0), 0, '0);
      send_token(mk(rpn_pkg::ACT_MIN, 0, 7'(rpn_pkg::STACK_DEPTH), 1), 0, '0);

      // Random part: mostly well-formed expressions, some raw noise tokens.
      sent = 0;
      while (sent < 1480) begin
         if (sent > 1250) calm = 1;
         if ($urandom_range(0, 7) == 0) begin
            send_token(mk(4'($urandom_range(0, 15)), $urandom, 7'($urandom),
                          1'($urandom_range(0, 1))), 0, '0);
            sent++;
         end else begin
            send_expression(got);
            sent += got;
         end
      end
      send_token(mk(rpn_pkg::ACT_NUMBER, 1, 0, 1), 0, '0);   // close any open expression
      req_ch.valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
